// File: design/sauv_pkg.sv
// ----------------------------------------------------------------------------
// sauv_pkg
// Shared types and constants of the Sauvola local binariser.
// ----------------------------------------------------------------------------
`default_nettype none

package sauv_pkg;

  localparam int MaxWidth      = 1024;
  localparam int MaxHeight     = 1024;
  localparam int MaxHalfWindow = 7;

  localparam int DimW      = 11;
  localparam int HwW       = 3;
  localparam int KW        = 8;
  localparam int CfgDataW  = 11;
  localparam int ScanW     = 21;
  localparam int AddrW     = 14;
  localparam int StoreDepth = 2 ** AddrW;

  localparam int SqrtInW   = 32;
  localparam int SqrtRootW = SqrtInW / 2;
  localparam int SqrtRemW  = SqrtRootW + 2;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_HALF_WINDOW  = 2'd2,
    REG_K_Q8         = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic white;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic                 vld;
    logic [SqrtRemW-1:0]  rem;
    logic [SqrtRootW-1:0] root;
    logic [SqrtInW-1:0]   dsh;
  } sqrt_stage_t;

endpackage

`default_nettype wire

// File: design/sauv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sauv_sqrt_cell
// One digit step of the integer square root, registered towards the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sauv_sqrt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sauv_pkg::sqrt_stage_t stage_i,
  output sauv_pkg::sqrt_stage_t stage_o
);
  import sauv_pkg::*;

  logic [SqrtRemW+1:0] cur;
  logic [SqrtRemW+1:0] trial;
  logic [SqrtRemW+1:0] diff;
  logic                ge;

  logic                 vld_q;
  logic [SqrtRemW-1:0]  rem_q;
  logic [SqrtRootW-1:0] root_q;
  logic [SqrtInW-1:0]   dsh_q;

  assign cur   = {stage_i.rem, stage_i.dsh[SqrtInW-1 -: 2]};
  assign trial = {2'b00, stage_i.root, 2'b01};
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= ge ? diff[SqrtRemW-1:0] : cur[SqrtRemW-1:0];
    root_q <= {stage_i.root[SqrtRootW-2:0], ge};
    dsh_q  <= {stage_i.dsh[SqrtInW-3:0], 2'b00};
  end

  assign stage_o = {vld_q, rem_q, root_q, dsh_q};

endmodule

`default_nettype wire

// File: design/sauvola_local_binarizer.sv
// Steps: a pixel is turned to gray and stored; a transfer that yields a result
// then divides its position by the width (a flush transfer skips the gray step),
// sweeps the clipped window (at most 225 pixels), runs the root chain and final compare, and waits out receiver stalls.
// Throughput: one item at a time; a pixel without a result stalls input while it
// is stored, the window sweep reads one pixel per cycle, then the 16-cell root chain.
// Reset: asynchronous, active low; registers to defaults, scan position to zero.
// ----------------------------------------------------------------------------
// sauvola_local_binarizer
// Streaming Sauvola binariser with gray line store and root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sauvola_local_binarizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sauv_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sauv_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  sauv_pkg::cfg_idx_e                  cfg_idx_i,
  input  logic [sauv_pkg::CfgDataW-1:0]       cfg_data_i
);
  import sauv_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_GRAY  = 14'b00000000000010,
    S_DIV   = 14'b00000000000100,
    S_RDG0  = 14'b00000000001000,
    S_SWEEP = 14'b00000000010000,
    S_DRAIN = 14'b00000000100000,
    S_MUL   = 14'b00000001000000,
    S_SUB   = 14'b00000010000000,
    S_SQRT  = 14'b00000100000000,
    S_F1    = 14'b00001000000000,
    S_F2    = 14'b00010000000000,
    S_F3    = 14'b00100000000000,
    S_F4    = 14'b01000000000000,
    S_F5    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [DimW-1:0] width_q, height_q;
  logic [HwW-1:0]  hw_q;
  logic [KW-1:0]   k_q;

  logic [DimW-1:0]  w_c, h_c;
  logic [ScanW-1:0] total, lag, total_lag;
  logic [2*DimW-1:0] wh_prod;

  logic [ScanW-1:0] scan_q;
  logic [ScanW-1:0] scan_inc;
  logic             in_xfer;
  logic             over, pix_in, produce;

  logic [17:0]      gsum_q;
  logic [38:0]      gprod;
  logic [AddrW-1:0] wa_q;
  logic             produce_q;
  logic [ScanW-1:0] p_q;
  logic             done_q;

  logic [ScanW-1:0] div_num_q;
  logic [DimW-1:0]  div_rem_q;
  logic [4:0]       div_cnt_q;
  logic [DimW:0]    div_sh;
  logic             div_ge;

  logic [DimW-1:0]  xx, yy;
  logic [DimW-1:0]  r0, r1, c0, c1;
  logic [DimW-1:0]  row_q, col_q;
  logic [ScanW-1:0] base_q;
  logic [2*DimW-1:0] base_prod;

  logic [7:0]       mem_q [StoreDepth];
  logic [7:0]       rd_q;
  logic [AddrW-1:0] rd_addr;
  logic [ScanW-1:0] sweep_sum;
  logic             acc_v_q, g0_pend_q;

  logic [7:0]       cnt_q;
  logic [15:0]      s_q;
  logic [23:0]      q_q;
  logic [7:0]       g0_q;

  logic [31:0]      nq_q, ss_q, d_q;
  logic             sq_go_q;
  sqrt_stage_t      chain [SqrtRootW+1];
  logic [SqrtRootW-1:0] root_q;

  logic [15:0]        nn_q;
  logic signed [17:0] t_q;
  logic [23:0]        lhs_q;
  logic signed [26:0] kt_q;
  logic signed [26:0] m_full;
  logic [25:0]        m_q;
  logic [41:0]        rhs_q;
  logic               white;
  logic               load_out;

  logic               out_valid_q;
  out_item_t          out_q;

  // geometry
  always_comb begin
    if (width_q == '0) begin
      w_c = DimW'(1);
    end else if (width_q > DimW'(MaxWidth)) begin
      w_c = DimW'(MaxWidth);
    end else begin
      w_c = width_q;
    end
    if (height_q == '0) begin
      h_c = DimW'(1);
    end else if (height_q > DimW'(MaxHeight)) begin
      h_c = DimW'(MaxHeight);
    end else begin
      h_c = height_q;
    end
  end

  assign wh_prod   = w_c * h_c;
  assign total     = wh_prod[ScanW-1:0];
  assign lag       = ScanW'(hw_q) * ScanW'(w_c) + ScanW'(hw_q);
  assign total_lag = total + lag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(640);
      height_q <= DimW'(480);
      hw_q     <= HwW'(MaxHalfWindow);
      k_q      <= KW'(51);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        REG_HALF_WINDOW:  hw_q     <= cfg_data_i[HwW-1:0];
        REG_K_Q8:         k_q      <= cfg_data_i[KW-1:0];
        default:          k_q      <= k_q;
      endcase
    end
  end

  // input side
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign scan_inc   = scan_q + ScanW'(1);
  assign over       = (scan_q >= total_lag);
  assign pix_in     = (scan_q < total);
  assign produce    = (scan_q >= lag);

  assign gprod = 39'(gsum_q) * 39'd1073742;

  // division of the pixel position by the row width
  assign div_sh = {div_rem_q, div_num_q[ScanW-1]};
  assign div_ge = (div_sh >= {1'b0, w_c});
  assign xx     = div_rem_q;
  assign yy     = div_num_q[DimW-1:0];

  // clipped window
  always_comb begin
    r0 = (yy >= DimW'(hw_q)) ? yy - DimW'(hw_q) : '0;
    r1 = ((yy + DimW'(hw_q)) < h_c) ? yy + DimW'(hw_q) : h_c - DimW'(1);
    c0 = (xx >= DimW'(hw_q)) ? xx - DimW'(hw_q) : '0;
    c1 = ((xx + DimW'(hw_q)) < w_c) ? xx + DimW'(hw_q) : w_c - DimW'(1);
  end

  assign base_prod = r0 * w_c;
  assign sweep_sum = base_q + ScanW'(col_q);
  assign rd_addr   = (state_q == S_RDG0) ? p_q[AddrW-1:0] : sweep_sum[AddrW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && !over && !(pix_in && in_data_i.cmd)) begin
          if (pix_in) begin
            state_d = S_GRAY;
          end else if (produce) begin
            state_d = S_DIV;
          end
        end
      end
      S_GRAY:  state_d = produce_q ? S_DIV : S_IDLE;
      S_DIV:   state_d = (div_cnt_q == '0) ? S_RDG0 : S_DIV;
      S_RDG0:  state_d = S_SWEEP;
      S_SWEEP: state_d = (col_q == c1 && row_q == r1) ? S_DRAIN : S_SWEEP;
      S_DRAIN: state_d = S_MUL;
      S_MUL:   state_d = S_SUB;
      S_SUB:   state_d = S_SQRT;
      S_SQRT:  state_d = chain[SqrtRootW].vld ? S_F1 : S_SQRT;
      S_F1:    state_d = S_F2;
      S_F2:    state_d = S_F3;
      S_F3:    state_d = S_F4;
      S_F4:    state_d = S_F5;
      S_F5:    state_d = load_out ? S_IDLE : S_F5;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      scan_q    <= '0;
      acc_v_q   <= 1'b0;
      g0_pend_q <= 1'b0;
      sq_go_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_v_q   <= (state_q == S_SWEEP);
      g0_pend_q <= (state_q == S_RDG0);
      sq_go_q   <= (state_q == S_SUB);
      if (in_xfer) begin
        if (over) begin
          scan_q <= '0;
        end else if (!(pix_in && in_data_i.cmd)) begin
          if (produce && ((scan_q - lag == total - ScanW'(1)) || (scan_inc >= total_lag))) begin
            scan_q <= '0;
          end else begin
            scan_q <= scan_inc;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      gsum_q    <= 18'(in_data_i.red) * 18'd299 + 18'(in_data_i.green) * 18'd587
                 + 18'(in_data_i.blue) * 18'd114;
      wa_q      <= scan_q[AddrW-1:0];
      produce_q <= produce;
      p_q       <= scan_q - lag;
      done_q    <= (scan_q - lag == total - ScanW'(1));
      div_num_q <= scan_q - lag;
      div_rem_q <= '0;
      div_cnt_q <= 5'(ScanW - 1);
    end
    if (state_q == S_GRAY) begin
      mem_q[wa_q] <= gprod[37:30];
    end
    if (state_q == S_DIV) begin
      div_rem_q <= div_ge ? DimW'(div_sh - {1'b0, w_c}) : div_sh[DimW-1:0];
      div_num_q <= {div_num_q[ScanW-2:0], div_ge};
      div_cnt_q <= div_cnt_q - 5'd1;
    end
    rd_q <= mem_q[rd_addr];
    if (state_q == S_RDG0) begin
      row_q  <= r0;
      col_q  <= c0;
      base_q <= base_prod[ScanW-1:0];
      cnt_q  <= '0;
      s_q    <= '0;
      q_q    <= '0;
    end
    if (state_q == S_SWEEP) begin
      if (col_q == c1) begin
        col_q  <= c0;
        row_q  <= row_q + DimW'(1);
        base_q <= base_q + ScanW'(w_c);
      end else begin
        col_q <= col_q + DimW'(1);
      end
    end
    if (acc_v_q) begin
      cnt_q <= cnt_q + 8'd1;
      s_q   <= s_q + 16'(rd_q);
      q_q   <= q_q + 24'(rd_q) * 24'(rd_q);
    end
    if (g0_pend_q) begin
      g0_q <= rd_q;
    end
    if (state_q == S_MUL) begin
      nq_q <= 32'(cnt_q) * 32'(q_q);
      ss_q <= 32'(s_q) * 32'(s_q);
    end
    if (state_q == S_SUB) begin
      d_q <= nq_q - ss_q;
    end
    if (state_q == S_SQRT) begin
      root_q <= chain[SqrtRootW].root;
    end
    if (state_q == S_F1) begin
      nn_q <= 16'(cnt_q) * 16'(cnt_q);
      t_q  <= $signed({2'b00, root_q}) - $signed({3'b000, cnt_q, 7'd0});
    end
    if (state_q == S_F2) begin
      lhs_q <= 24'(g0_q) * 24'(nn_q);
      kt_q  <= 27'($signed({1'b0, k_q}) * t_q);
    end
    if (state_q == S_F3) begin
      m_q <= m_full[25:0];
    end
    if (state_q == S_F4) begin
      rhs_q <= 42'(s_q) * 42'(m_q);
    end
  end

  assign m_full = $signed({4'b0000, cnt_q, 15'd0}) + kt_q;

  // root cell chain
  assign chain[0] = {sq_go_q, {SqrtRemW{1'b0}}, {SqrtRootW{1'b0}}, d_q};

  for (genvar i = 0; i < SqrtRootW; i++) begin : g_cell
    sauv_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // output register
  assign white    = ({3'b000, lhs_q, 15'd0} > rhs_q);
  assign load_out = (state_q == S_F5) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.white      <= white;
      out_q.frame_done <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: design/sauv_checker.sv
// ----------------------------------------------------------------------------
// sauv_checker
// Port level checks of the Sauvola local binariser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sauv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sauv_pkg::out_item_t out_data_o
);

  // held result stays put while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // a new result only appears at the end of busy work
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without prior work");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

  // the block is free to take input right after leaving reset
  a_reset_ready: assert property (@(posedge clk_i)
    !rst_ni |=> !in_stall_o)
    else $error("input stalled after reset");

endmodule

bind sauvola_local_binarizer sauv_checker u_sauv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
